>>> hw/rtl/pendulum_computed_torque_pd_top_macros.svh
// Assertion macros for the pendulum computed-torque PD controller.
// Included by the top level; no other dependencies.
`ifndef PENDULUM_COMPUTED_TORQUE_PD_TOP_MACROS_SVH
`define PENDULUM_COMPUTED_TORQUE_PD_TOP_MACROS_SVH
`ifndef SYNTH
`define PCTPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pctpd: check failed");
`define PCTPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pctpd: check failed");
`else
`define PCTPD_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PCTPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/pctpd_pkg.sv
// Shared types, constants, saturation and microcode for the computed-torque PD controller.
// No dependencies.
`default_nettype none

package pctpd_pkg;

    localparam int COS_ENTRIES_DEFAULT = 1024;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COS_W      = 18;
    localparam int A_W        = 33;
    localparam int B_W        = 32;
    localparam int PROD_W     = A_W + B_W;
    localparam int STEP_W     = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd11;

    localparam logic [15:0] KP_RESET      = 16'd1024;
    localparam logic [15:0] KD_RESET      = 16'd845;
    localparam logic [13:0] FS_RESET      = 14'd100;
    localparam logic [23:0] INERTIA_RESET = 24'd3716;
    localparam logic [23:0] GRAVITY_RESET = 24'd86704;

    localparam logic signed [B_W-1:0] INV_TWO_PI_Q32 = 32'sd683565276;

    localparam longint unsigned QUARTER_Q32 = 64'd1073741824;
    localparam longint unsigned HALF_Q32    = 64'd2147483648;
    localparam longint unsigned FULL_Q32    = 64'd4294967296;
    localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
    localparam longint          ONE_Q30     = 64'sd1073741824;

    localparam logic signed [PROD_W-1:0] SAT_MAX = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_MIN = {{(PROD_W-31){1'b1}}, {31{1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_DERIV_GAIN     = 3'd1,
        CFG_SAMPLE_RATE    = 3'd2,
        CFG_INERTIA_COEFF  = 3'd3,
        CFG_GRAVITY_COEFF  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] reference_angle;
        logic signed [15:0] measured_angle;
        logic signed [15:0] measured_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] torque_out;
        logic signed [31:0] angle_error;
        logic signed [31:0] rate_error;
        logic signed [31:0] ref_rate;
        logic signed [31:0] ref_accel;
    } t_out;

    typedef enum logic [3:0] {
        A_ZERO, A_REF_DIFF, A_ANGLE, A_RATE_DIFF, A_TMP, A_EDOT, A_ERR, A_COS, A_INNER
    } t_asel;

    typedef enum logic [2:0] {
        B_ZERO, B_FS, B_ENTRIES, B_INV, B_KD, B_KP, B_GRAV, B_INERTIA
    } t_bsel;

    typedef enum logic [2:0] {
        WB_NONE, WB_RATE, WB_TMP, WB_ACCEL, WB_INDEX, WB_ADD, WB_INNER, WB_DONE
    } t_wb;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_asel a_sel;
        t_bsel b_sel;
        t_wb   wb;
        t_jmp  jmp;
    } t_ucode;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[31:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // multiplier issue and writeback of the previous product share a step
    function automatic t_ucode ucode(input logic [STEP_W-1:0] step);
        t_ucode u;
        case (step)
            4'd0:    u = '{A_ZERO,      B_ZERO,     WB_NONE,  JMP_WAIT_IN};
            4'd1:    u = '{A_REF_DIFF,  B_FS,       WB_NONE,  JMP_NEXT};
            4'd2:    u = '{A_ANGLE,     B_ENTRIES,  WB_RATE,  JMP_NEXT};
            4'd3:    u = '{A_RATE_DIFF, B_FS,       WB_TMP,   JMP_NEXT};
            4'd4:    u = '{A_TMP,       B_INV,      WB_ACCEL, JMP_NEXT};
            4'd5:    u = '{A_EDOT,      B_KD,       WB_INDEX, JMP_NEXT};
            4'd6:    u = '{A_ERR,       B_KP,       WB_ADD,   JMP_NEXT};
            4'd7:    u = '{A_COS,       B_GRAV,     WB_ADD,   JMP_NEXT};
            4'd8:    u = '{A_ZERO,      B_ZERO,     WB_INNER, JMP_NEXT};
            4'd9:    u = '{A_INNER,     B_INERTIA,  WB_NONE,  JMP_NEXT};
            4'd10:   u = '{A_ZERO,      B_ZERO,     WB_ADD,   JMP_NEXT};
            4'd11:   u = '{A_ZERO,      B_ZERO,     WB_DONE,  JMP_WAIT_OUT};
            default: u = '{A_ZERO,      B_ZERO,     WB_NONE,  JMP_NEXT};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pctpd_cos_rom.sv
// Cosine ROM over one period, signed Q1.16, with registered read.
// Depends on pctpd_pkg; contents are built at elaboration.
`default_nettype none

module pctpd_cos_rom #(
    parameter int COS_TABLE_ENTRIES = pctpd_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic                                        i_clk,
    input  logic [$clog2(COS_TABLE_ENTRIES)-1:0]        i_idx,
    output logic signed [pctpd_pkg::COS_W-1:0]          o_cos
);
    import pctpd_pkg::*;

    // quadrant fold, Q30 Horner series, round to Q16
    function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned idx);
        longint unsigned t;
        longint unsigned w;
        longint unsigned x;
        longint unsigned x2;
        longint          h;
        longint          p;
        logic            neg;
        t   = (longint'(idx) << 32) / COS_TABLE_ENTRIES;
        neg = 1'b0;
        if (t < QUARTER_Q32) begin
            w = t;
        end else if (t < HALF_Q32) begin
            w   = HALF_Q32 - t;
            neg = 1'b1;
        end else if (t < HALF_Q32 + QUARTER_Q32) begin
            w   = t - HALF_Q32;
            neg = 1'b1;
        end else begin
            w = FULL_Q32 - t;
        end
        x  = (w * TWO_PI_Q30) >> 32;
        x2 = (x * x) >> 30;
        h  = ONE_Q30;
        for (int k = 0; k < 6; k++) begin
            p = longint'((x2 * longint'(h)) >> 30);
            case (k)
                0:       p = p / 132;
                1:       p = p / 90;
                2:       p = p / 56;
                3:       p = p / 30;
                4:       p = p / 12;
                default: p = p / 2;
            endcase
            h = ONE_Q30 - p;
            if (h < 0) begin
                h = 0;
            end
            if (h > ONE_Q30) begin
                h = ONE_Q30;
            end
        end
        h = (h + 64'sd8192) >>> 14;
        if (neg) begin
            h = -h;
        end
        return COS_W'(h);
    endfunction

    logic signed [COS_W-1:0] w_rom [COS_TABLE_ENTRIES];

    for (genvar gi = 0; gi < COS_TABLE_ENTRIES; gi++) begin : g_rom
        assign w_rom[gi] = cos_entry(gi);
    end

    always_ff @(posedge i_clk) begin
        o_cos <= w_rom[i_idx];
    end

endmodule

`default_nettype wire

>>> hw/rtl/pendulum_computed_torque_pd_top.sv
// Pendulum computed-torque PD controller with gravity compensation: top level.
// Depends on pctpd_pkg, pctpd_cos_rom and pendulum_computed_torque_pd_top_macros.svh.
//
// One item is taken per control tick; after acceptance the microcode steps run in order and the
// last step loads the output register once it is free. A new item is taken the cycle after the
// result is loaded, so no new item enters before the last one is done. The order is set by
// the microcode program, which passes every product through one shared 33x32 multiplier.
// Configuration registers reset to kp 4.0, kd 3.3, 100 ticks/s, inertia 0.0567 and gravity
// 1.323; writes to unknown indexes are dropped. Reference rate and acceleration come from
// backward differences against the previous tick's reference and rate.
`default_nettype none
`include "pendulum_computed_torque_pd_top_macros.svh"

module pendulum_computed_torque_pd_top #(
    parameter int COS_TABLE_ENTRIES = pctpd_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pctpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pctpd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  pctpd_pkg::t_in                       i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output pctpd_pkg::t_out                      o_out
);
    import pctpd_pkg::*;

    localparam int IDX_W = $clog2(COS_TABLE_ENTRIES);
    localparam int QW    = IDX_W + 3;
    localparam logic signed [QW-1:0]     N_Q       = QW'(COS_TABLE_ENTRIES);
    localparam logic signed [PROD_W-1:0] ROUND_Q44 = PROD_W'(1) <<< 44 >>> 1;

    logic [15:0]              r_kp;
    logic [15:0]              r_kd;
    logic [13:0]              r_fs;
    logic [23:0]              r_inertia;
    logic [23:0]              r_grav;

    logic signed [15:0]       r_ref;
    logic signed [15:0]       r_ma;
    logic signed [15:0]       r_mr;
    logic signed [15:0]       r_prev_ref;
    logic signed [31:0]       r_prev_rate;
    logic signed [31:0]       r_rate;
    logic signed [31:0]       r_edot;
    logic signed [31:0]       r_accel;
    logic signed [31:0]       r_inner;
    logic signed [31:0]       r_tmp;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic [IDX_W-1:0]         r_idx;
    logic signed [COS_W-1:0]  w_cos;

    logic [STEP_W-1:0]        r_step;
    logic [STEP_W-1:0]        n_step;
    logic                     r_out_valid;
    t_out                     r_out;
    t_ucode                   w_uc;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_fire_done;
    logic signed [16:0]       w_ref_diff;
    logic signed [16:0]       w_ang_diff;
    logic signed [31:0]       w_err;
    logic signed [A_W-1:0]    w_rate_diff;
    logic signed [A_W-1:0]    w_a;
    logic signed [B_W-1:0]    w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [PROD_W-1:0] w_prod_rnd;
    logic signed [QW-1:0]     w_q0;
    logic signed [QW-1:0]     w_q1;
    logic signed [QW-1:0]     w_q2;
    logic signed [QW-1:0]     w_q3;

    pctpd_cos_rom #(
        .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
    ) u_cos_rom (
        .i_clk (i_clk),
        .i_idx (r_idx),
        .o_cos (w_cos)
    );

    assign w_uc        = ucode(r_step);
    assign o_in_stall  = (r_step != STEP_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_fire_done = (w_uc.wb == WB_DONE) && w_out_free;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_ref_diff  = 17'(r_ref) - 17'(r_prev_ref);
    assign w_ang_diff  = 17'(r_ref) - 17'(r_ma);
    assign w_err       = 32'(w_ang_diff) <<< 4;
    assign w_rate_diff = A_W'(r_rate) - A_W'(r_prev_rate);

    // table index: round, then wrap into one period
    assign w_prod_rnd  = r_prod + ROUND_Q44;
    assign w_q0        = w_prod_rnd[44+QW-1:44];
    assign w_q1        = (w_q0 < 0) ? w_q0 + N_Q : w_q0;
    assign w_q2        = (w_q1 < 0) ? w_q1 + N_Q : w_q1;
    assign w_q3        = (w_q2 >= N_Q) ? w_q2 - N_Q : w_q2;

    always_comb begin
        case (w_uc.a_sel)
            A_REF_DIFF:  w_a = A_W'(w_ref_diff);
            A_ANGLE:     w_a = A_W'(r_ma);
            A_RATE_DIFF: w_a = w_rate_diff;
            A_TMP:       w_a = A_W'(r_tmp);
            A_EDOT:      w_a = A_W'(r_edot);
            A_ERR:       w_a = A_W'(w_err);
            A_COS:       w_a = A_W'(w_cos);
            A_INNER:     w_a = A_W'(r_inner);
            default:     w_a = '0;
        endcase
    end

    always_comb begin
        case (w_uc.b_sel)
            B_FS:        w_b = signed'(B_W'(r_fs));
            B_ENTRIES:   w_b = B_W'(COS_TABLE_ENTRIES);
            B_INV:       w_b = INV_TWO_PI_Q32;
            B_KD:        w_b = signed'(B_W'(r_kd));
            B_KP:        w_b = signed'(B_W'(r_kp));
            B_GRAV:      w_b = signed'(B_W'(r_grav));
            B_INERTIA:   w_b = signed'(B_W'(r_inertia));
            default:     w_b = '0;
        endcase
    end

    assign w_mul = w_a * w_b;

    always_comb begin
        n_step = r_step;
        case (w_uc.jmp)
            JMP_NEXT: begin
                n_step = r_step + STEP_W'(1);
            end
            JMP_WAIT_IN: begin
                if (w_in_acc) begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            JMP_WAIT_OUT: begin
                if (w_out_free) begin
                    n_step = STEP_IDLE;
                end
            end
            default: begin
                n_step = STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= KP_RESET;
            r_kd      <= KD_RESET;
            r_fs      <= FS_RESET;
            r_inertia <= INERTIA_RESET;
            r_grav    <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PROP_GAIN:     r_kp      <= i_cfg_data[15:0];
                CFG_DERIV_GAIN:    r_kd      <= i_cfg_data[15:0];
                CFG_SAMPLE_RATE:   r_fs      <= i_cfg_data[13:0];
                CFG_INERTIA_COEFF: r_inertia <= i_cfg_data;
                CFG_GRAVITY_COEFF: r_grav    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_out_valid <= 1'b0;
            r_prev_ref  <= '0;
            r_prev_rate <= '0;
        end else begin
            r_step <= n_step;
            if (w_fire_done) begin
                r_out_valid <= 1'b1;
                r_prev_ref  <= r_ref;
                r_prev_rate <= r_rate;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        if (w_in_acc) begin
            r_ref <= i_in.reference_angle;
            r_ma  <= i_in.measured_angle;
            r_mr  <= i_in.measured_rate;
        end
        case (w_uc.wb)
            WB_RATE: begin
                r_rate <= sat32(r_prod <<< 4);
            end
            WB_TMP: begin
                r_tmp  <= r_prod[31:0];
                r_edot <= sat32(PROD_W'(r_rate) - (PROD_W'(r_mr) <<< 4));
            end
            WB_ACCEL: begin
                r_accel <= sat32(r_prod);
            end
            WB_INDEX: begin
                r_idx <= w_q3[IDX_W-1:0];
                r_acc <= PROD_W'(r_accel) <<< 8;
            end
            WB_ADD: begin
                r_acc <= r_acc + r_prod;
            end
            WB_INNER: begin
                r_inner <= sat32(r_acc >>> 8);
                r_acc   <= r_prod;
            end
            WB_DONE: begin
                if (w_out_free) begin
                    r_out.torque_out  <= sat32(r_acc >>> 16);
                    r_out.angle_error <= w_err;
                    r_out.rate_error  <= r_edot;
                    r_out.ref_rate    <= r_rate;
                    r_out.ref_accel   <= r_accel;
                end
            end
            default: ;
        endcase
    end

    `PCTPD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_acc, r_step == STEP_FIRST)
    `PCTPD_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, w_fire_done, o_out_valid && r_step == STEP_IDLE)
    `PCTPD_ASSERT_IMPL(a_rise_after_done, i_clk, i_rst_n, $rose(o_out_valid), $past(r_step) == STEP_LAST)

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for pendulum_computed_torque_pd_top: a directed table, then random
// phases under several gain settings and idle patterns, checked against a cycle-free predictor.
// Depends on pctpd_pkg and the RTL of the controller only.
`timescale 1ns / 100ps

module tb_top;
    import pctpd_pkg::*;

    localparam int COS_N       = 1024;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_GAP     = 20;
    localparam int REPORT_MAX  = 10;
    localparam int N_PHASES    = 7;

    typedef longint unsigned u64_t;

    localparam longint ONE_Q30_L  = 64'sd1073741824;
    localparam u64_t   PH_QUARTER = 64'd1073741824;
    localparam u64_t   PH_HALF    = 64'd2147483648;
    localparam u64_t   PH_FULL    = 64'd4294967296;
    localparam u64_t   TWO_PI_30  = 64'd6746518852;
    localparam longint INV_2PI_32 = 64'sd683565276;

    typedef enum logic [1:0] {
        GAINS_NOMINAL, GAINS_RANDOM, GAINS_MAX, GAINS_MIN
    } gain_set_e;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in                   item;
        logic                  typed;
        t_out                  expv;
    } stim_row_t;

    typedef struct packed {
        int        n_items;
        int        snd_idle;
        int        rcv_stall;
        gain_set_e gains;
        logic      hold;
    } phase_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    t_in                   in_item  = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_item;

    // predictor copy of the registers and the tick state
    logic [15:0]        kp        = 16'd1024;
    logic [15:0]        kd        = 16'd845;
    logic [13:0]        fs        = 14'd100;
    logic [23:0]        inertia   = 24'd3716;
    logic [23:0]        grav      = 24'd86704;
    logic signed [15:0] last_ref  = '0;
    logic signed [31:0] last_rate = '0;
    longint             cos_lut [COS_N];

    t_out torque_cmds_due [$];
    int   mismatches    = 0;
    int   cycles        = 0;
    int   snd_idle_pct  = 0;
    int   rcv_stall_pct = 0;

    pendulum_computed_torque_pd_top #(
        .COS_TABLE_ENTRIES(COS_N)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[pendulum_computed_torque_pd_top] ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < rcv_stall_pct);
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic int sat16(input int v);
        if (v > 32767) begin
            return 32767;
        end else if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // one control tick; advances the stored reference and reference rate
    function automatic t_out predict_torque_cmd(input t_in it);
        longint r, ang, spd, rate_s, kp_s, kd_s, jx, gx;
        longint rate, accel, e, edot, inner, trq, idx;
        t_out   res;
        r      = longint'(it.reference_angle);
        ang    = longint'(it.measured_angle);
        spd    = longint'(it.measured_rate);
        rate_s = longint'(fs);
        kp_s   = longint'(kp);
        kd_s   = longint'(kd);
        jx     = longint'(inertia);
        gx     = longint'(grav);
        rate   = clip32((r - longint'(last_ref)) * rate_s * 16);
        accel  = clip32((rate - longint'(last_rate)) * rate_s);
        e      = (r - ang) * 16;
        edot   = clip32(rate - spd * 16);
        inner  = clip32((accel * 256 + kd_s * edot + kp_s * e) >>> 8);
        idx    = ((ang * INV_2PI_32 * COS_N + (longint'(1) <<< 43)) >>> 44) % COS_N;
        if (idx < 0) begin
            idx += COS_N;
        end
        trq    = clip32((jx * inner + gx * cos_lut[idx]) >>> 16);
        last_ref  = it.reference_angle;
        last_rate = rate[31:0];
        res.torque_out  = trq[31:0];
        res.angle_error = e[31:0];
        res.rate_error  = edot[31:0];
        res.ref_rate    = rate[31:0];
        res.ref_accel   = accel[31:0];
        return res;
    endfunction

    function automatic stim_row_t item_row(input int r, input int x1, input int x2);
        stim_row_t s;
        s = '0;
        s.item.reference_angle = 16'(r);
        s.item.measured_angle  = 16'(x1);
        s.item.measured_rate   = 16'(x2);
        return s;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t s;
        s = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%s mismatch: expected %h, got %h", name, want, got);
            end
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (torque_cmds_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("result with no item pending: %h", out_item);
                end
            end else begin
                want = torque_cmds_due.pop_front();
                check_field("torque_out", want.torque_out, out_item.torque_out);
                check_field("angle_error", want.angle_error, out_item.angle_error);
                check_field("rate_error", want.rate_error, out_item.rate_error);
                check_field("ref_rate", want.ref_rate, out_item.ref_rate);
                check_field("ref_accel", want.ref_accel, out_item.ref_accel);
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx)
            CFG_PROP_GAIN:     kp      = data[15:0];
            CFG_DERIV_GAIN:    kd      = data[15:0];
            CFG_SAMPLE_RATE:   fs      = data[13:0];
            CFG_INERTIA_COEFF: inertia = data;
            CFG_GRAVITY_COEFF: grav    = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (torque_cmds_due.size() != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic send(input stim_row_t row);
        int   gap;
        t_out pred;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) begin
            gap++;
        end
        cfg_we = 1'b0;
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = row.item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        pred = predict_torque_cmd(row.item);
        torque_cmds_due.push_back(row.typed ? row.expv : pred);
        @(negedge clk);
    endtask

    task automatic load_gains(input gain_set_e gains);
        case (gains)
            GAINS_NOMINAL: begin
                write_reg(CFG_PROP_GAIN, 24'd1024);
                write_reg(CFG_DERIV_GAIN, 24'd845);
                write_reg(CFG_SAMPLE_RATE, 24'($urandom_range(400, 1)));
                write_reg(CFG_INERTIA_COEFF, 24'd3716);
                write_reg(CFG_GRAVITY_COEFF, 24'd86704);
            end
            GAINS_RANDOM: begin
                for (int k = 0; k < 2 ** CFG_IDX_W; k++) begin
                    write_reg(CFG_IDX_W'(k), 24'($urandom));
                end
            end
            GAINS_MAX: begin
                for (int k = 0; k < 2 ** CFG_IDX_W; k++) begin
                    write_reg(CFG_IDX_W'(k), '1);
                end
            end
            default: begin
                write_reg(CFG_PROP_GAIN, '0);
                write_reg(CFG_DERIV_GAIN, '0);
                write_reg(CFG_SAMPLE_RATE, 24'd1);
                write_reg(CFG_INERTIA_COEFF, '0);
                write_reg(CFG_GRAVITY_COEFF, '0);
            end
        endcase
    endtask

    initial begin
        longint    taylor_div [6];
        u64_t      ph, w, x, xsq;
        longint    h, p;
        logic      neg;
        stim_row_t dir_rows [$];
        stim_row_t zero_row, row;
        phase_t    phases [N_PHASES];
        int        traj, x1;

        // cosine table, one period folded onto the first quadrant
        taylor_div = '{132, 90, 56, 30, 12, 2};
        for (int i = 0; i < COS_N; i++) begin
            ph  = (u64_t'(i) << 32) / COS_N;
            neg = 1'b0;
            if (ph < PH_QUARTER) begin
                w = ph;
            end else if (ph < PH_HALF) begin
                w   = PH_HALF - ph;
                neg = 1'b1;
            end else if (ph < PH_HALF + PH_QUARTER) begin
                w   = ph - PH_HALF;
                neg = 1'b1;
            end else begin
                w = PH_FULL - ph;
            end
            x   = (w * TWO_PI_30) >> 32;
            xsq = (x * x) >> 30;
            h   = ONE_Q30_L;
            for (int k = 0; k < 6; k++) begin
                p = longint'((xsq * u64_t'(h)) >> 30);
                h = ONE_Q30_L - p / taylor_div[k];
                if (h < 0) begin
                    h = 0;
                end
                if (h > ONE_Q30_L) begin
                    h = ONE_Q30_L;
                end
            end
            h = (h + 8192) >>> 14;
            cos_lut[i] = neg ? -h : h;
        end

        // zero angles, zero rates: torque is the gravity term at cos(0)
        zero_row       = item_row(0, 0, 0);
        zero_row.typed = 1'b1;
        zero_row.expv  = '{32'sd86704, 32'sd0, 32'sd0, 32'sd0, 32'sd0};

        dir_rows.push_back(zero_row);
        dir_rows.push_back(zero_row);
        dir_rows.push_back(item_row(32767, 0, 0));
        dir_rows.push_back(item_row(-32768, 0, 0));
        dir_rows.push_back(item_row(-32768, 32767, 32767));
        dir_rows.push_back(item_row(32767, -32768, -32768));
        dir_rows.push_back(item_row(0, 12868, 0));
        dir_rows.push_back(item_row(0, -12868, 0));
        dir_rows.push_back(item_row(0, 6434, 0));
        dir_rows.push_back(item_row(0, 25736, 0));
        dir_rows.push_back(item_row(0, 32767, -1));
        dir_rows.push_back(cfg_row(CFG_SAMPLE_RATE, '0));
        dir_rows.push_back(zero_row);
        dir_rows.push_back(item_row(32767, 100, -100));
        for (int k = int'(CFG_GRAVITY_COEFF) + 1; k < 2 ** CFG_IDX_W; k++) begin
            dir_rows.push_back(cfg_row(CFG_IDX_W'(k), '1));
        end
        dir_rows.push_back(cfg_row(CFG_SAMPLE_RATE, 24'h003FFF));
        dir_rows.push_back(item_row(-32768, 0, 0));
        dir_rows.push_back(item_row(32767, 0, 0));
        dir_rows.push_back(cfg_row(CFG_PROP_GAIN, 24'h00FFFF));
        dir_rows.push_back(cfg_row(CFG_DERIV_GAIN, 24'h00FFFF));
        dir_rows.push_back(cfg_row(CFG_INERTIA_COEFF, 24'hFFFFFF));
        dir_rows.push_back(cfg_row(CFG_GRAVITY_COEFF, 24'hFFFFFF));
        dir_rows.push_back(item_row(32767, -32768, -32768));
        dir_rows.push_back(item_row(-32768, 32767, 32767));
        dir_rows.push_back(item_row(0, 0, 0));

        phases[0] = '{70, 0, 0, GAINS_NOMINAL, 1'b0};
        phases[1] = '{70, 59, 0, GAINS_RANDOM, 1'b0};
        phases[2] = '{70, 0, 59, GAINS_MAX, 1'b0};
        phases[3] = '{70, 28, 28, GAINS_MIN, 1'b0};
        phases[4] = '{70, 0, 0, GAINS_RANDOM, 1'b1};
        phases[5] = '{70, 59, 0, GAINS_NOMINAL, 1'b0};
        phases[6] = '{80, 0, 59, GAINS_RANDOM, 1'b0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send(dir_rows[i]);
            end
        end

        traj = 0;
        for (int ph_i = 0; ph_i < N_PHASES; ph_i++) begin
            drain();
            snd_idle_pct  = phases[ph_i].snd_idle;
            rcv_stall_pct = phases[ph_i].rcv_stall;
            load_gains(phases[ph_i].gains);
            for (int k = 0; k < phases[ph_i].n_items; k++) begin
                if (phases[ph_i].hold && k == phases[ph_i].n_items / 2) begin
                    drain();
                end
                if ($urandom_range(99) < 60) begin
                    // smooth trajectory with the measurement tracking it
                    traj = sat16(traj + int'($urandom_range(200)) - 100);
                    x1   = sat16(traj + int'($urandom_range(64)) - 32);
                    row  = item_row(traj, x1, int'($urandom_range(2000)) - 1000);
                end else begin
                    row = item_row(int'($urandom), int'($urandom), int'($urandom));
                end
                send(row);
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && torque_cmds_due.size() == 0) begin
            $display("[pendulum_computed_torque_pd_top] OK");
        end else begin
            $display("[pendulum_computed_torque_pd_top] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pctpd_pkg.sv
hw/rtl/pctpd_cos_rom.sv
hw/rtl/pendulum_computed_torque_pd_top.sv
test/tb_top.sv
